[src/psnap_pkg.sv]
// ----------------------------------------------------------------------------
// psnap_pkg
// Shared types, constants and the segment classifier for the 45-degree
// polyline point snapper.
// ----------------------------------------------------------------------------
`default_nettype none

package psnap_pkg;

	localparam int MAX_POINTS_DEF = 256;

	typedef struct packed {
		logic        new_polygon;
		logic [31:0] x_coord;
		logic [31:0] y_coord;
	} in_item_t;

	typedef enum logic [2:0] {
		VERDICT_APPEND    = 3'd0,
		VERDICT_DUPLICATE = 3'd1,
		VERDICT_FULL      = 3'd2,
		VERDICT_REPLACE   = 3'd3,
		VERDICT_REMOVE    = 3'd4
	} verdict_t;

	typedef struct packed {
		logic [31:0] snapped_x;
		logic [31:0] snapped_y;
		verdict_t    verdict;
		logic [7:0]  point_total;
		logic        closed;
	} out_item_t;

	typedef struct packed {
		logic [31:0] x;
		logic [31:0] y;
	} point_t;

	typedef enum logic [2:0] {
		CLS_H    = 3'd0,
		CLS_D1   = 3'd1,
		CLS_V    = 3'd2,
		CLS_D2   = 3'd3,
		CLS_NONE = 3'd4
	} cls_t;

	typedef struct packed {
		logic take_first;
		logic append;
		logic replace;
		logic remove;
	} step_ctl_t;

	// Earlier tests take precedence, so the diagonals win over the axes.
	function automatic cls_t classify(input logic signed [32:0] dx,
	                                  input logic signed [32:0] dy);
		cls_t c;
		if (dy == -dx) begin
			c = CLS_D2;
		end else if (dy == dx) begin
			c = CLS_D1;
		end else if (dx == 33'sd0) begin
			c = CLS_V;
		end else if (dy == 33'sd0) begin
			c = CLS_H;
		end else begin
			c = CLS_NONE;
		end
		return c;
	endfunction

endpackage

`default_nettype wire

[src/psnap_store.sv]
// ----------------------------------------------------------------------------
// psnap_store
// Point memory with one write port and one registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module psnap_store #(
	parameter int MAX_POINTS = 256,
	parameter int CW         = $clog2(MAX_POINTS)
) (
	input  wire logic              clk,
	input  wire logic              wr_en,
	input  wire logic [CW-1:0]     wr_addr,
	input  wire psnap_pkg::point_t wr_data,
	input  wire logic [CW-1:0]     rd_addr,
	output psnap_pkg::point_t      rd_data
);
	import psnap_pkg::*;

	point_t mem [MAX_POINTS];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		rd_data <= mem[rd_addr];
	end

endmodule

`default_nettype wire

[src/psnap_snap.sv]
// ----------------------------------------------------------------------------
// psnap_snap
// Snaps one point against the last stored point and decides how the
// polyline changes: start, append, merge, removal or ignore.
// ----------------------------------------------------------------------------
`default_nettype none

module psnap_snap #(
	parameter int MAX_POINTS = 256,
	parameter int CW         = $clog2(MAX_POINTS)
) (
	input  wire psnap_pkg::in_item_t item,
	input  wire logic [CW-1:0]       count,
	input  wire psnap_pkg::point_t   last,
	input  wire psnap_pkg::point_t   prev,
	input  wire psnap_pkg::point_t   first,
	output psnap_pkg::out_item_t     result,
	output psnap_pkg::step_ctl_t     ctl,
	output psnap_pkg::point_t        snapped,
	output logic [CW-1:0]            count_next
);
	import psnap_pkg::*;

	localparam logic [CW-1:0] FULL_AT = CW'(MAX_POINTS - 2);
	localparam logic [CW-1:0] ONE     = CW'(1);
	localparam logic [CW-1:0] THREE   = CW'(3);

	logic signed [32:0] dx, dy, ndx, ndy, pdx, pdy;
	logic [32:0]        adx, ady;
	logic               vert, horiz, dup, full, take_first, merge, hits_prev;
	logic [33:0]        dd, dsum;
	logic [31:0]        diag_x;
	cls_t               ca, cb;
	point_t             last_next;

	always_comb begin
		take_first = item.new_polygon || (count == '0);
		dx  = {item.x_coord[31], item.x_coord} - {last.x[31], last.x};
		dy  = {item.y_coord[31], item.y_coord} - {last.y[31], last.y};
		adx = dx[32] ? 33'(-dx) : 33'(dx);
		ady = dy[32] ? 33'(-dy) : 33'(dy);
		vert  = {1'b0, ady} > {adx, 1'b0};
		horiz = {1'b0, adx} > {ady, 1'b0};
		dup   = (dx == 33'sd0) && (dy == 33'sd0);
		full  = count >= FULL_AT;

		dd   = dx[32] ? 34'(34'd0 - {1'b0, ady}) : {1'b0, ady};
		dsum = {{2{last.x[31]}}, last.x} + dd;
		if (dsum[33:31] == 3'b000 || dsum[33:31] == 3'b111) begin
			diag_x = dsum[31:0];
		end else if (!dsum[33]) begin
			diag_x = 32'h7fff_ffff;
		end else begin
			diag_x = 32'h8000_0000;
		end

		if (vert) begin
			snapped.x = last.x;
		end else if (horiz) begin
			snapped.x = item.x_coord;
		end else begin
			snapped.x = diag_x;
		end
		snapped.y = horiz && !vert ? last.y : item.y_coord;

		ndx = {snapped.x[31], snapped.x} - {last.x[31], last.x};
		ndy = {snapped.y[31], snapped.y} - {last.y[31], last.y};
		pdx = {last.x[31], last.x} - {prev.x[31], prev.x};
		pdy = {last.y[31], last.y} - {prev.y[31], prev.y};
		cb  = classify(ndx, ndy);
		ca  = classify(pdx, pdy);
		merge     = (count != ONE) && (ca == cb) && (ca != CLS_NONE);
		hits_prev = (snapped == prev);

		ctl        = '0;
		count_next = count;
		result.snapped_x = item.x_coord;
		result.snapped_y = item.y_coord;
		result.verdict   = VERDICT_APPEND;
		last_next        = last;
		priority if (take_first) begin
			ctl.take_first = 1'b1;
			count_next     = ONE;
			last_next      = point_t'{x: item.x_coord, y: item.y_coord};
		end else if (dup) begin
			result.verdict = VERDICT_DUPLICATE;
		end else if (full) begin
			result.verdict = VERDICT_FULL;
		end else if (merge && hits_prev) begin
			ctl.remove       = 1'b1;
			count_next       = count - ONE;
			result.verdict   = VERDICT_REMOVE;
			result.snapped_x = snapped.x;
			result.snapped_y = snapped.y;
			last_next        = prev;
		end else if (merge) begin
			ctl.replace      = 1'b1;
			result.verdict   = VERDICT_REPLACE;
			result.snapped_x = snapped.x;
			result.snapped_y = snapped.y;
			last_next        = snapped;
		end else begin
			ctl.append       = 1'b1;
			count_next       = count + ONE;
			result.snapped_x = snapped.x;
			result.snapped_y = snapped.y;
			last_next        = snapped;
		end

		result.point_total = 8'(count_next);
		result.closed      = (count_next > THREE) && !ctl.take_first && (last_next == first);
	end

endmodule

`default_nettype wire

[src/polyline_point_snap_45_core.sv]
// ----------------------------------------------------------------------------
// polyline_point_snap_45_core
// Builds a polyline of horizontal, vertical and 45-degree segments from
// entered points, one point per cycle unless the output stalls.
//
//   Channel | Signals                     | Direction
//   in      | in_valid, in_ready, in_data  | into the block
//   out     | out_valid, out_ready, out_data | out of the block
//
// Each point passes an input register, the snap logic and the result
// register, and one point per cycle is sustained while the output is not
// stalled.
// The last, previous and first points sit in registers; the point before
// the previous one is read from the point memory every cycle.
// Reset clears the point count and both valid flags; memory is not cleared.
// A stalled output holds its result; the input register then fills and
// in_ready drops.
// ----------------------------------------------------------------------------
`default_nettype none

module polyline_point_snap_45_core #(
	parameter int MAX_POINTS = psnap_pkg::MAX_POINTS_DEF
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 in_valid,
	output logic                      in_ready,
	input  wire psnap_pkg::in_item_t  in_data,
	output logic                      out_valid,
	input  wire logic                 out_ready,
	output psnap_pkg::out_item_t      out_data
);
	import psnap_pkg::*;

	localparam int CW = $clog2(MAX_POINTS);
	localparam logic [CW-1:0] ONE   = CW'(1);
	localparam logic [CW-1:0] THREE = CW'(3);

	logic          valid_s1;
	in_item_t      item_s1;
	logic          out_valid_q;
	out_item_t     out_q;
	logic [CW-1:0] count_q;
	point_t        last_q, prev_q, first_q;
	point_t        prev2;
	logic          advance;

	out_item_t     result;
	step_ctl_t     ctl;
	point_t        snapped;
	logic [CW-1:0] count_next, count_eff;
	logic          wr_en;
	logic [CW-1:0] wr_addr, rd_addr;
	point_t        wr_data;

	assign advance   = valid_s1 && (!out_valid_q || out_ready);
	assign in_ready  = !valid_s1 || advance;
	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	psnap_snap #(.MAX_POINTS(MAX_POINTS), .CW(CW)) u_snap (
		.item       (item_s1),
		.count      (count_q),
		.last       (last_q),
		.prev       (prev_q),
		.first      (first_q),
		.result     (result),
		.ctl        (ctl),
		.snapped    (snapped),
		.count_next (count_next)
	);

	always_comb begin
		wr_en   = advance && (ctl.take_first || ctl.append || ctl.replace);
		wr_data = snapped;
		wr_addr = count_q;
		priority if (ctl.take_first) begin
			wr_addr = '0;
			wr_data = point_t'{x: item_s1.x_coord, y: item_s1.y_coord};
		end else if (ctl.replace) begin
			wr_addr = count_q - ONE;
		end else begin
			wr_addr = count_q;
		end
		count_eff = advance ? count_next : count_q;
		rd_addr   = count_eff - THREE;
	end

	psnap_store #(.MAX_POINTS(MAX_POINTS), .CW(CW)) u_store (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (wr_data),
		.rd_addr (rd_addr),
		.rd_data (prev2)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			out_valid_q <= 1'b0;
			count_q     <= '0;
		end else begin
			if (in_ready) begin
				valid_s1 <= in_valid;
			end
			if (advance) begin
				out_valid_q <= 1'b1;
				count_q     <= count_next;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			item_s1 <= in_data;
		end
		if (advance) begin
			out_q <= result;
			priority if (ctl.take_first) begin
				first_q <= point_t'{x: item_s1.x_coord, y: item_s1.y_coord};
				last_q  <= point_t'{x: item_s1.x_coord, y: item_s1.y_coord};
			end else if (ctl.append) begin
				prev_q <= last_q;
				last_q <= snapped;
			end else if (ctl.replace) begin
				last_q <= snapped;
			end else if (ctl.remove) begin
				last_q <= prev_q;
				prev_q <= prev2;
			end else begin
				last_q <= last_q;
			end
		end
	end

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(MAX_POINTS - 2))
		else $error("point count exceeds store limit");

	a_ctl_onehot: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0({ctl.take_first, ctl.append, ctl.replace, ctl.remove}))
		else $error("more than one store update selected");

	a_remove_count: assert property (@(posedge clk) disable iff (!arst_n)
		advance && ctl.remove |=> count_q == $past(count_q) - ONE)
		else $error("removal did not shorten the polyline by one");

	a_new_polygon: assert property (@(posedge clk) disable iff (!arst_n)
		advance && item_s1.new_polygon |=> count_q == ONE && out_valid_q)
		else $error("new polygon did not restart the store");

endmodule

`default_nettype wire
